// ===== hw/rtl/softened_point_mass_force_macros.svh =====
// assertion macros for the softened point-mass force block
// expects clk and rst_n in the scope of each use
`ifndef SOFTENED_POINT_MASS_FORCE_MACROS_SVH
`define SOFTENED_POINT_MASS_FORCE_MACROS_SVH
`ifndef SYNTHESIS
`define SPMF_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("spmf check failed");
`define SPMF_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("spmf check failed");
`else
`define SPMF_ASSERT_IMP(label, cond, prop)
`define SPMF_ASSERT_NXT(label, cond, prop)
`endif
`endif

// ===== hw/rtl/spmf_pkg.sv =====
// shared constants and types of the softened point-mass force block
// no dependencies
`default_nettype none
package spmf_pkg;
  localparam int DATA_W    = 32;
  localparam int LEVEL_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 33;
  localparam int QUO_W     = 31;
  localparam logic [DATA_W-1:0] CORE_SQ_RESET = 32'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAT_X,
    CFG_SAT_Y,
    CFG_SAT_Z,
    CFG_SAT_MASS,
    CFG_CORE_SQ,
    CFG_SHADOW_ON,
    CFG_MIN_LEVEL
  } cfg_idx_t;

  // per-beat flags carried alongside the datapath
  typedef struct packed {
    logic       skip;
    logic [5:0] neg;
  } spmf_sb_t;
endpackage
`default_nettype wire

// ===== hw/rtl/spmf_if.sv =====
// valid/ready channel interfaces: particle input, force result, register write
// depends on spmf_pkg
`default_nettype none
interface spmf_in_if;
  import spmf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   pos_x;
  logic signed [DATA_W-1:0]   pos_y;
  logic signed [DATA_W-1:0]   pos_z;
  logic        [LEVEL_W-1:0]  step_level;
  modport source (output valid, pos_x, pos_y, pos_z, step_level, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, step_level, output ready);
endinterface

interface spmf_out_if;
  import spmf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] acc_x;
  logic signed [DATA_W-1:0] acc_y;
  logic signed [DATA_W-1:0] acc_z;
  logic signed [DATA_W-1:0] potential;
  logic                     skipped;
  modport source (output valid, acc_x, acc_y, acc_z, potential, skipped, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, potential, skipped, output ready);
endinterface

interface spmf_cfg_if;
  import spmf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/spmf_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, saturation flag
// no dependencies; advances only when en is high
`default_nettype none
module spmf_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 34,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic          sat
);
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [CW-1:0] rem_r   [QW+1];
  logic [CW-1:0] rem_nxt [QW+1];
  logic [DW-1:0] den_r   [QW+1];
  logic [DW-1:0] den_nxt [QW+1];
  logic [QW-1:0] q_r     [QW+1];
  logic [QW-1:0] q_nxt   [QW+1];
  logic          sat_r   [QW+1];
  logic          sat_nxt [QW+1];

  always_comb begin
    logic [CW-1:0] sh;
    // first stage flags quotients of 2^QW or more
    rem_nxt[0] = CW'(num);
    den_nxt[0] = den;
    q_nxt[0]   = '0;
    sat_nxt[0] = CW'(num) >= (CW'(den) << QW);
    for (int s = 1; s <= QW; s++) begin
      sh         = CW'(den_r[s-1]) << (QW - s);
      den_nxt[s] = den_r[s-1];
      sat_nxt[s] = sat_r[s-1];
      if (rem_r[s-1] >= sh) begin
        rem_nxt[s] = rem_r[s-1] - sh;
        q_nxt[s]   = q_r[s-1] | (QW'(1) << (QW - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
        q_r[s]   <= q_nxt[s];
        sat_r[s] <= sat_nxt[s];
      end
    end
  end

  assign q   = q_r[QW];
  assign sat = sat_r[QW];
endmodule
`default_nettype wire

// ===== hw/rtl/softened_point_mass_force.sv =====
// Softened point-mass force unit. Takes one particle position and step level per
// beat and returns acceleration and potential of one satellite, plus its mirror
// when shadow mode is set. Fully pipelined: one beat enters every cycle unless the
// output stalls. The depth is set by the 34-stage square root and the 32-stage
// dividers. When a result is held at the output the whole pipeline stalls with it,
// and in_bus.ready drops.
// Depends on spmf_pkg, spmf_if, spmf_div_pipe and the assertion macro header.
`default_nettype none
`include "softened_point_mass_force_macros.svh"
module softened_point_mass_force #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  spmf_in_if.sink     in_bus,
  spmf_out_if.source  out_bus,
  spmf_cfg_if.sink    cfg_bus
);
  import spmf_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RW     = 68 - F;
  localparam int XW     = RW + F;
  localparam int SW     = XW / 2;
  localparam int LO_W   = RW / 2;
  localparam int HI_W   = RW - LO_W;
  localparam int NM_W   = DATA_W + MAG_W;
  localparam int PHI_NW = DATA_W + F;
  localparam int ACC_NW = NM_W + F;
  localparam int ACC_DW = SW + RW;
  localparam int SQ0    = 3;
  localparam int P1     = SQ0 + SW;
  localparam int P2     = P1 + 1;
  localparam int DV     = P2 + 1 + QUO_W;
  localparam int NST    = DV + 2;
  localparam logic signed [DATA_W:0] SAT_MAX = {2'b00, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W:0] SAT_MIN = {2'b11, {(DATA_W-1){1'b0}}};

  // configuration registers
  logic signed [DATA_W-1:0]  sat_r [3];
  logic        [DATA_W-1:0]  mass_r;
  logic        [DATA_W-1:0]  core_r;
  logic                      shadow_r;
  logic        [LEVEL_W-1:0] min_level_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r[0]    <= '0;
      sat_r[1]    <= '0;
      sat_r[2]    <= '0;
      mass_r      <= '0;
      core_r      <= CORE_SQ_RESET;
      shadow_r    <= 1'b0;
      min_level_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_idx_t'(cfg_bus.index))
        CFG_SAT_X:     sat_r[0]    <= cfg_bus.data;
        CFG_SAT_Y:     sat_r[1]    <= cfg_bus.data;
        CFG_SAT_Z:     sat_r[2]    <= cfg_bus.data;
        CFG_SAT_MASS:  mass_r      <= cfg_bus.data;
        CFG_CORE_SQ:   core_r      <= cfg_bus.data;
        CFG_SHADOW_ON: shadow_r    <= cfg_bus.data[0];
        CFG_MIN_LEVEL: min_level_r <= cfg_bus.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic           en;
  logic [NST-1:0] v_r;
  spmf_sb_t       sb_r [DV+1];
  spmf_sb_t       sb_nxt;

  assign en           = !v_r[NST-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_bus.valid};
    end
  end

  // stage 0: offsets from the direct (lane 0) and mirror (lane 1) satellite
  logic [MAG_W-1:0] mag_nxt [2][3];
  logic [MAG_W-1:0] mag0_r  [2][3];

  always_comb begin
    logic signed [DATA_W-1:0] p [3];
    logic signed [MAG_W-1:0]  d;
    p[0] = in_bus.pos_x;
    p[1] = in_bus.pos_y;
    p[2] = in_bus.pos_z;
    sb_nxt.skip = in_bus.step_level < min_level_r;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        if (l == 0) begin
          d = MAG_W'(p[k]) - MAG_W'(sat_r[k]);
        end else begin
          d = MAG_W'(p[k]) + MAG_W'(sat_r[k]);
        end
        mag_nxt[l][k]      = d[MAG_W-1] ? -d : d;
        sb_nxt.neg[l*3+k]  = !d[MAG_W-1];
      end
    end
  end

  // stages 1 and 2: squares, then R = core + sum of squares
  logic [SQ_W-1:0]  sq_r   [2][3];
  logic [MAG_W-1:0] mag1_r [2][3];
  logic [MAG_W-1:0] mag2_r [2][3];
  logic [RW-1:0]    rr_r   [2];
  logic [RW-1:0]    rr_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rr_nxt[l] = RW'(core_r) + RW'(sq_r[l][0] >> F) + RW'(sq_r[l][1] >> F)
                + RW'(sq_r[l][2] >> F);
      if (rr_nxt[l] == '0) begin
        rr_nxt[l] = RW'(1);
      end
    end
  end

  // square root stages, one result bit each
  logic [XW-1:0]    sx_r     [2][SW];
  logic [XW-1:0]    sx_nxt   [2][SW];
  logic [XW:0]      sres_r   [2][SW];
  logic [XW:0]      sres_nxt [2][SW];
  logic [RW-1:0]    srr_r    [2][SW];
  logic [MAG_W-1:0] smag_r   [2][3][SW];

  always_comb begin
    logic [XW-1:0] x_in;
    logic [XW:0]   res_in;
    logic [XW:0]   bitv;
    logic [XW:0]   t;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < SW; j++) begin
        if (j == 0) begin
          x_in   = XW'(rr_r[l]) << F;
          res_in = '0;
        end else begin
          x_in   = sx_r[l][j-1];
          res_in = sres_r[l][j-1];
        end
        bitv = (XW+1)'(1) << (2 * (SW - 1 - j));
        t    = res_in + bitv;
        if ({1'b0, x_in} >= t) begin
          sx_nxt[l][j]   = x_in - t[XW-1:0];
          sres_nxt[l][j] = (res_in >> 1) + bitv;
        end else begin
          sx_nxt[l][j]   = x_in;
          sres_nxt[l][j] = res_in >> 1;
        end
      end
    end
  end

  // product stages: r*R in two partial products, m*|d|
  logic [SW+LO_W-1:0] pplo_r [2];
  logic [SW+HI_W-1:0] pphi_r [2];
  logic [NM_W-1:0]    nm_r   [2][3];
  logic [SW-1:0]      rt_r   [2];
  logic [ACC_DW-1:0]  dacc_r [2];
  logic [ACC_NW-1:0]  nacc_r [2][3];
  logic [SW-1:0]      dphi_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int s = 1; s <= DV; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          mag0_r[l][k] <= mag_nxt[l][k];
          sq_r[l][k]   <= mag0_r[l][k] * mag0_r[l][k];
          mag1_r[l][k] <= mag0_r[l][k];
          mag2_r[l][k] <= mag1_r[l][k];
          smag_r[l][k][0] <= mag2_r[l][k];
          for (int j = 1; j < SW; j++) begin
            smag_r[l][k][j] <= smag_r[l][k][j-1];
          end
          nm_r[l][k]   <= mass_r * smag_r[l][k][SW-1];
          nacc_r[l][k] <= {nm_r[l][k], {F{1'b0}}};
        end
        rr_r[l] <= rr_nxt[l];
        srr_r[l][0] <= rr_r[l];
        for (int j = 0; j < SW; j++) begin
          sx_r[l][j]   <= sx_nxt[l][j];
          sres_r[l][j] <= sres_nxt[l][j];
          if (j > 0) begin
            srr_r[l][j] <= srr_r[l][j-1];
          end
        end
        pplo_r[l] <= sres_r[l][SW-1][SW-1:0] * srr_r[l][SW-1][LO_W-1:0];
        pphi_r[l] <= sres_r[l][SW-1][SW-1:0] * srr_r[l][SW-1][RW-1:LO_W];
        rt_r[l]   <= sres_r[l][SW-1][SW-1:0];
        dacc_r[l] <= ACC_DW'(pplo_r[l]) + (ACC_DW'(pphi_r[l]) << LO_W);
        dphi_r[l] <= rt_r[l];
      end
    end
  end

  // dividers: index 3 of each lane is the potential
  logic [QUO_W-1:0] q_all [2][4];
  logic             s_all [2][4];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < 3; k++) begin : g_axis
      spmf_div_pipe #(.NW(ACC_NW), .DW(ACC_DW), .QW(QUO_W)) u_acc_div (
        .clk (clk),
        .en  (en),
        .num (nacc_r[l][k]),
        .den (dacc_r[l]),
        .q   (q_all[l][k]),
        .sat (s_all[l][k])
      );
    end
    spmf_div_pipe #(.NW(PHI_NW), .DW(SW), .QW(QUO_W)) u_phi_div (
      .clk (clk),
      .en  (en),
      .num ({mass_r, {F{1'b0}}}),
      .den (dphi_r[l]),
      .q   (q_all[l][3]),
      .sat (s_all[l][3])
    );
  end

  // output stage: signed terms, mirror add, saturation, skip
  logic [DATA_W-1:0] res_r   [4];
  logic [DATA_W-1:0] res_nxt [4];
  logic              skip_r;

  always_comb begin
    logic signed [DATA_W:0]   tv [2];
    logic signed [DATA_W+1:0] sum;
    logic                     neg;
    logic [7:0]               negs;
    // potential term is always negative
    negs = {1'b1, sb_r[DV].neg[5:3], 1'b1, sb_r[DV].neg[2:0]};
    for (int k = 0; k < 4; k++) begin
      for (int l = 0; l < 2; l++) begin
        neg = negs[l*4+k];
        if (s_all[l][k]) begin
          tv[l] = neg ? SAT_MIN : SAT_MAX;
        end else if (neg) begin
          tv[l] = -$signed({2'b00, q_all[l][k]});
        end else begin
          tv[l] = $signed({2'b00, q_all[l][k]});
        end
      end
      if (shadow_r) begin
        sum = (DATA_W+2)'(tv[0]) + (DATA_W+2)'(tv[1]);
      end else begin
        sum = (DATA_W+2)'(tv[0]);
      end
      if (sum > (DATA_W+2)'(SAT_MAX)) begin
        res_nxt[k] = SAT_MAX[DATA_W-1:0];
      end else if (sum < (DATA_W+2)'(SAT_MIN)) begin
        res_nxt[k] = SAT_MIN[DATA_W-1:0];
      end else begin
        res_nxt[k] = sum[DATA_W-1:0];
      end
      if (sb_r[DV].skip) begin
        res_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= res_nxt[k];
      end
      skip_r <= sb_r[DV].skip;
    end
  end

  assign out_bus.valid     = v_r[NST-1];
  assign out_bus.acc_x     = res_r[0];
  assign out_bus.acc_y     = res_r[1];
  assign out_bus.acc_z     = res_r[2];
  assign out_bus.potential = res_r[3];
  assign out_bus.skipped   = skip_r;

  `SPMF_ASSERT_IMP(a_skip_zero, out_bus.valid && out_bus.skipped, (out_bus.acc_x == '0) && (out_bus.acc_y == '0) && (out_bus.acc_z == '0) && (out_bus.potential == '0))
  `SPMF_ASSERT_IMP(a_phi_sign, out_bus.valid && !out_bus.skipped, out_bus.potential[DATA_W-1] || (out_bus.potential == '0))
  `SPMF_ASSERT_IMP(a_ready_empty, !out_bus.valid, in_bus.ready)
  `SPMF_ASSERT_NXT(a_hold_pipe, !en, $stable(v_r))
endmodule
`default_nettype wire
